@@ rtl/pnpg_pkg.sv @@
package pnpg_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int TABLE_BITS     = 8;
   localparam int TABLE_SIZE     = 1 << TABLE_BITS;
   localparam int PIX_BITS       = 9;
   localparam int FREQ_BITS      = 16;
   localparam int PROD_BITS      = PIX_BITS + FREQ_BITS;
   localparam int OCT_BITS       = 4;
   localparam int GRAY_BITS      = 8;
   localparam int MAX_OCTAVES    = 8;
   localparam int NOISE_BITS     = FRAC_BITS + 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRACTAL_MODE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASIC_FREQUENCY   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRACTAL_FREQUENCY = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OCTAVE_COUNT      = 2'd3;

   localparam logic [FREQ_BITS-1:0] BASIC_FREQUENCY_RESET   = 16'd655;
   localparam logic [FREQ_BITS-1:0] FRACTAL_FREQUENCY_RESET = 16'd328;
   localparam logic [OCT_BITS-1:0]  OCTAVE_COUNT_RESET      = 4'd8;

   localparam logic CMD_TABLE_WRITE = 1'b0;
   localparam logic CMD_PIXEL       = 1'b1;

   typedef struct packed {
      logic                  en;
      logic [TABLE_BITS-1:0] index;
      logic [7:0]            value;
   } tbl_wr_type;

endpackage

@@ rtl/pnpg_lane.sv @@
module pnpg_lane #(
   parameter int LANE = 0
) (
   input  logic                                   clock,
   input  logic                                   adv,
   input  pnpg_pkg::tbl_wr_type                   wr_l1,
   input  pnpg_pkg::tbl_wr_type                   wr_l2,
   input  logic [pnpg_pkg::PROD_BITS-1:0]         prod_x,
   input  logic [pnpg_pkg::PROD_BITS-1:0]         prod_y,
   output logic signed [pnpg_pkg::NOISE_BITS-1:0] noise
);

   localparam int F   = pnpg_pkg::FRAC_BITS;
   localparam int TB  = pnpg_pkg::TABLE_BITS;
   localparam int CW  = F + TB;
   localparam int AW  = F + 6;
   localparam int BW  = F + 5;
   localparam int GW  = F + 3;
   localparam int NW  = pnpg_pkg::NOISE_BITS;
   localparam int PW  = 2 * F + 8;
   localparam int ONE = 1 << F;

   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] half;
      half = PW'(1) << (F - 1);
      return (v + half) >>> F;
   endfunction

   function automatic logic signed [AW-1:0] fade_a(input logic [F-1:0] t);
      logic [AW-1:0] r;
      r = AW'(t) * AW'(6) - (AW'(15) << F);
      return $signed(r);
   endfunction

   function automatic logic signed [GW-1:0] grad(input logic [7:0] h,
                                                 input logic signed [GW-1:0] dx,
                                                 input logic signed [GW-1:0] dy);
      logic signed [GW-1:0] r;
      unique case (h[1:0])
         2'd1: r = dx + dy;
         2'd2: r = -dx - dy;
         2'd3: r = dx - dy;
         2'd0: r = dy - dx;
      endcase
      return r;
   endfunction

   function automatic logic [F:0] clamp_fade(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] c;
      logic [F:0]           r;
      c = rnd(v);
      if (c < 0) begin
         r = '0;
      end else if (c > ONE) begin
         r = (F+1)'(ONE);
      end else begin
         r = c[F:0];
      end
      return r;
   endfunction

   logic [7:0] mem_a [pnpg_pkg::TABLE_SIZE];
   logic [7:0] mem_b [pnpg_pkg::TABLE_SIZE];
   logic [7:0] mem_c [pnpg_pkg::TABLE_SIZE];

   logic [CW-1:0] shx, shy;
   logic [TB-1:0] x0, y0_in, y1;
   logic [F-1:0]  fx_in, fy_in;

   logic [7:0]    p0_ff, p1_ff;
   logic [TB-1:0] y0_ff;
   logic [F-1:0]  fx3_ff, fy3_ff, fx4_ff, fy4_ff, fx5_ff, fy5_ff, fx6_ff, fy6_ff;
   logic [7:0]    h00_ff, h01_ff, h10_ff, h11_ff;

   logic signed [PW-1:0] fpu1_ff, fpv1_ff, fpu2_ff, fpv2_ff;
   logic signed [PW-1:0] fpu3_ff, fpv3_ff, fpu4_ff, fpv4_ff;
   logic signed [BW-1:0] fbu, fbv, fcu1, fcv1, fcu2, fcv2;
   logic signed [F+1:0]  tsu3, tsv3, tsu4, tsv4, tsu5, tsv5, tsu6, tsv6;

   logic signed [GW-1:0] dx, dy, dx1, dy1;
   logic signed [GW-1:0] gbl5_ff, gtl5_ff, gbr5_ff, gtr5_ff;
   logic signed [GW-1:0] gbl6_ff, gtl6_ff, gbr6_ff, gtr6_ff;
   logic signed [GW-1:0] gbl7_ff, gtl7_ff, gbr7_ff, gtr7_ff;
   logic signed [GW-1:0] gbl8_ff, gtl8_ff, gbr8_ff, gtr8_ff;
   logic signed [GW-1:0] gbl9_ff, gbr9_ff;

   logic [F:0] u8_ff, v8_ff, u9_ff;
   logic signed [GW:0]   dv0, dv1;
   logic signed [F+1:0]  vs, us;
   logic signed [PW-1:0] lp0_ff, lp1_ff, up_ff;
   logic signed [NW-1:0] l0, l1, l0_ff, noise_ff;
   logic signed [NW:0]   dl;

   assign shx   = CW'(prod_x) << LANE;
   assign shy   = CW'(prod_y) << LANE;
   assign x0    = shx[CW-1:F];
   assign y0_in = shy[CW-1:F];
   assign fx_in = shx[F-1:0];
   assign fy_in = shy[F-1:0];
   assign y1    = y0_ff + TB'(1);

   always_ff @(posedge clock) begin
      if (wr_l1.en) begin
         mem_a[wr_l1.index] <= wr_l1.value;
      end
      if (wr_l2.en) begin
         mem_b[wr_l2.index] <= wr_l2.value;
         mem_c[wr_l2.index] <= wr_l2.value;
      end
      if (adv) begin
         p0_ff  <= mem_a[x0];
         p1_ff  <= mem_a[x0 + TB'(1)];
         h00_ff <= mem_b[TB'(p0_ff) + y0_ff];
         h01_ff <= mem_b[TB'(p0_ff) + y1];
         h10_ff <= mem_c[TB'(p1_ff) + y0_ff];
         h11_ff <= mem_c[TB'(p1_ff) + y1];
      end
   end

   assign tsu3 = $signed({2'b00, fx3_ff});
   assign tsv3 = $signed({2'b00, fy3_ff});
   assign tsu4 = $signed({2'b00, fx4_ff});
   assign tsv4 = $signed({2'b00, fy4_ff});
   assign tsu5 = $signed({2'b00, fx5_ff});
   assign tsv5 = $signed({2'b00, fy5_ff});
   assign tsu6 = $signed({2'b00, fx6_ff});
   assign tsv6 = $signed({2'b00, fy6_ff});

   assign fbu  = BW'(rnd(fpu1_ff)) + BW'(10 * ONE);
   assign fbv  = BW'(rnd(fpv1_ff)) + BW'(10 * ONE);
   assign fcu1 = BW'(rnd(fpu2_ff));
   assign fcv1 = BW'(rnd(fpv2_ff));
   assign fcu2 = BW'(rnd(fpu3_ff));
   assign fcv2 = BW'(rnd(fpv3_ff));

   assign dx  = $signed(GW'(fx4_ff));
   assign dy  = $signed(GW'(fy4_ff));
   assign dx1 = dx - GW'(ONE);
   assign dy1 = dy - GW'(ONE);

   assign dv0 = (GW+1)'(gtl8_ff) - (GW+1)'(gbl8_ff);
   assign dv1 = (GW+1)'(gtr8_ff) - (GW+1)'(gbr8_ff);
   assign vs  = $signed({1'b0, v8_ff});
   assign us  = $signed({1'b0, u9_ff});
   assign l0  = NW'(gbl9_ff) + NW'(rnd(lp0_ff));
   assign l1  = NW'(gbr9_ff) + NW'(rnd(lp1_ff));
   assign dl  = (NW+1)'(l1) - (NW+1)'(l0);

   always_ff @(posedge clock) begin
      if (adv) begin
         y0_ff   <= y0_in;
         fx3_ff  <= fx_in;
         fy3_ff  <= fy_in;

         fx4_ff  <= fx3_ff;
         fy4_ff  <= fy3_ff;
         fpu1_ff <= fade_a(fx3_ff) * tsu3;
         fpv1_ff <= fade_a(fy3_ff) * tsv3;

         fx5_ff  <= fx4_ff;
         fy5_ff  <= fy4_ff;
         fpu2_ff <= fbu * tsu4;
         fpv2_ff <= fbv * tsv4;
         gbl5_ff <= grad(h00_ff, dx, dy);
         gtl5_ff <= grad(h01_ff, dx, dy1);
         gbr5_ff <= grad(h10_ff, dx1, dy);
         gtr5_ff <= grad(h11_ff, dx1, dy1);

         fx6_ff  <= fx5_ff;
         fy6_ff  <= fy5_ff;
         fpu3_ff <= fcu1 * tsu5;
         fpv3_ff <= fcv1 * tsv5;
         gbl6_ff <= gbl5_ff;
         gtl6_ff <= gtl5_ff;
         gbr6_ff <= gbr5_ff;
         gtr6_ff <= gtr5_ff;

         fpu4_ff <= fcu2 * tsu6;
         fpv4_ff <= fcv2 * tsv6;
         gbl7_ff <= gbl6_ff;
         gtl7_ff <= gtl6_ff;
         gbr7_ff <= gbr6_ff;
         gtr7_ff <= gtr6_ff;

         u8_ff   <= clamp_fade(fpu4_ff);
         v8_ff   <= clamp_fade(fpv4_ff);
         gbl8_ff <= gbl7_ff;
         gtl8_ff <= gtl7_ff;
         gbr8_ff <= gbr7_ff;
         gtr8_ff <= gtr7_ff;

         lp0_ff  <= vs * dv0;
         lp1_ff  <= vs * dv1;
         gbl9_ff <= gbl8_ff;
         gbr9_ff <= gbr8_ff;
         u9_ff   <= u8_ff;

         up_ff   <= us * dl;
         l0_ff   <= l0;

         noise_ff <= l0_ff + NW'(rnd(up_ff));
      end
   end

   assign noise = noise_ff;

endmodule

@@ rtl/perlin_noise_pixel_generator.sv @@
// Gradient-noise pixel generator with a load port for its permutation table.
// Input channel (req_*): an item with req_cmd low writes req_table_value into
// table entry req_table_index and gives no result; an item with req_cmd high
// computes the gray level of pixel (req_pixel_x, req_pixel_y).
// Result channel (rsp_*): one item carrying rsp_gray_value per pixel item, in
// the order the pixel items were accepted.
// Configuration (csr_*): mode, frequencies and octave count; csr_ready is
// always high. The user must write registers only while the block holds no
// items; the block itself does not enforce this. Throughput is one item per
// clock cycle in both modes unless a result is stalled. Every octave has its
// own lane with private copies of the table, so all octaves are evaluated at
// once; the fade polynomial chain of four multiplies sets the pipeline depth.
// Reset clears the pipeline and loads the register defaults; table contents
// are undefined until written.
// When rsp_stall holds a result, the whole pipeline halts and req_stall is
// raised in the same cycle; nothing is lost or repeated.
module perlin_noise_pixel_generator #(
   parameter int MAX_OCTAVES = pnpg_pkg::MAX_OCTAVES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic [pnpg_pkg::PIX_BITS-1:0]           req_pixel_x,
   input  logic [pnpg_pkg::PIX_BITS-1:0]           req_pixel_y,
   input  logic [pnpg_pkg::TABLE_BITS-1:0]         req_table_index,
   input  logic [7:0]                              req_table_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [pnpg_pkg::GRAY_BITS-1:0]          rsp_gray_value,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pnpg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [pnpg_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int F    = pnpg_pkg::FRAC_BITS;
   localparam int NW   = pnpg_pkg::NOISE_BITS;
   localparam int ACW  = NW + MAX_OCTAVES;
   localparam int SH   = F + MAX_OCTAVES - 1;
   localparam int GRW  = ACW + 9;
   localparam int BNW  = NW + 10;
   localparam int NST  = 12;
   localparam int ONE  = 1 << F;
   localparam int OB   = pnpg_pkg::OCT_BITS;

   logic                                adv;
   logic [NST:1]                        pix_ff, pix_in;
   logic [3:1]                          wr_ff, wr_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                                fractal_mode_ff;
   logic [pnpg_pkg::FREQ_BITS-1:0]      basic_frequency_ff, fractal_frequency_ff;
   logic [OB-1:0]                       octave_count_ff;

   logic [pnpg_pkg::PIX_BITS-1:0]       px1_ff, py1_ff;
   logic [pnpg_pkg::TABLE_BITS-1:0]     tidx1_ff, tidx2_ff, tidx3_ff;
   logic [7:0]                          tval1_ff, tval2_ff, tval3_ff;
   logic [pnpg_pkg::FREQ_BITS-1:0]      freq;
   logic [pnpg_pkg::PROD_BITS-1:0]      prodx2_ff, prody2_ff;
   pnpg_pkg::tbl_wr_type                wr_l1, wr_l2;

   logic signed [NW-1:0]                noise [MAX_OCTAVES];
   logic signed [ACW-1:0]               acc_in, acc_ff;
   logic signed [NW-1:0]                n0_ff;

   logic [GRW-1:0]                      fsum, fsh;
   logic signed [NW:0]                  nb;
   logic [BNW-1:0]                      bsum, bsh;
   logic [pnpg_pkg::GRAY_BITS-1:0]      gray_in, gray_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   assign pix_in       = {pix_ff[NST-1:1], req_valid && (req_cmd == pnpg_pkg::CMD_PIXEL)};
   assign wr_in        = {wr_ff[2:1], req_valid && (req_cmd == pnpg_pkg::CMD_TABLE_WRITE)};
   assign rsp_valid_in = pix_ff[NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         wr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pix_ff       <= pix_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fractal_mode_ff      <= 1'b0;
         basic_frequency_ff   <= pnpg_pkg::BASIC_FREQUENCY_RESET;
         fractal_frequency_ff <= pnpg_pkg::FRACTAL_FREQUENCY_RESET;
         octave_count_ff      <= pnpg_pkg::OCTAVE_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pnpg_pkg::CSR_FRACTAL_MODE:      fractal_mode_ff      <= csr_wdata[0];
            pnpg_pkg::CSR_BASIC_FREQUENCY:   basic_frequency_ff   <= csr_wdata;
            pnpg_pkg::CSR_FRACTAL_FREQUENCY: fractal_frequency_ff <= csr_wdata;
            pnpg_pkg::CSR_OCTAVE_COUNT:      octave_count_ff      <= csr_wdata[OB-1:0];
         endcase
      end
   end

   assign freq = fractal_mode_ff ? fractal_frequency_ff : basic_frequency_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff    <= req_pixel_x;
         py1_ff    <= req_pixel_y;
         tidx1_ff  <= req_table_index;
         tval1_ff  <= req_table_value;
         prodx2_ff <= px1_ff * freq;
         prody2_ff <= py1_ff * freq;
         tidx2_ff  <= tidx1_ff;
         tval2_ff  <= tval1_ff;
         tidx3_ff  <= tidx2_ff;
         tval3_ff  <= tval2_ff;
      end
   end

   assign wr_l1 = '{en: adv && wr_ff[2], index: tidx2_ff, value: tval2_ff};
   assign wr_l2 = '{en: adv && wr_ff[3], index: tidx3_ff, value: tval3_ff};

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      pnpg_lane #(
         .LANE (k)
      ) u_lane (
         .clock  (clock),
         .adv    (adv),
         .wr_l1  (wr_l1),
         .wr_l2  (wr_l2),
         .prod_x (prodx2_ff),
         .prod_y (prody2_ff),
         .noise  (noise[k])
      );
   end

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         if (octave_count_ff > OB'(k)) begin
            acc_in = acc_in + (ACW'(noise[k]) <<< (MAX_OCTAVES - 1 - k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff  <= acc_in;
         n0_ff   <= noise[0];
         gray_ff <= gray_in;
      end
   end

   assign fsum = (GRW'(acc_ff) << 8) - GRW'(acc_ff) + (GRW'(1) << (SH - 1));
   assign fsh  = fsum >> SH;
   assign nb   = (NW+1)'(n0_ff) + (NW+1)'(ONE);
   assign bsum = (BNW'(nb) << 8) - BNW'(nb) + BNW'(ONE);
   assign bsh  = bsum >> (F + 1);

   always_comb begin
      if (fractal_mode_ff) begin
         if (acc_ff <= 0) begin
            gray_in = '0;
         end else if (|fsh[GRW-1:8]) begin
            gray_in = '1;
         end else begin
            gray_in = fsh[7:0];
         end
      end else begin
         if (nb <= 0) begin
            gray_in = '0;
         end else if (|bsh[BNW-1:8]) begin
            gray_in = '1;
         end else begin
            gray_in = bsh[7:0];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_value = gray_ff;

endmodule

@@ rtl/pnpg_checker.sv @@
module pnpg_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_ready,
   input logic [pnpg_pkg::GRAY_BITS-1:0] rsp_gray_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gray_value))
      else $error("stalled result item changed");

   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_csr_ready: assert property (@(posedge clock) csr_ready)
      else $error("configuration port not ready");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item after reset");

endmodule

bind perlin_noise_pixel_generator pnpg_checker u_pnpg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .csr_ready      (csr_ready),
   .rsp_gray_value (rsp_gray_value)
);
